// ----- hdl/lpc_pkg.sv -----
// ============================================================================
// lpc_pkg : shared types and constants for the lux approximation pipeline
// Fixed-point widths, segment tables and register indexes.
// ============================================================================
package lpc_pkg;

    localparam int RAW_W     = 16;
    localparam int SCALE_W   = 19;           // 0x7517 << 4 fits in 19 bits
    localparam int SCALE_FRAC = 10;
    localparam int CNT_W     = RAW_W + SCALE_W - SCALE_FRAC;  // scaled count, 25 bits
    localparam int Q_W       = 12;           // ratio quotient kept to 2^12 - 1
    localparam int COEF_W    = 10;
    localparam int PROD_W    = CNT_W + COEF_W;
    localparam int LUX_FRAC  = 14;
    localparam int LUX_W     = 16;
    localparam int NSEG      = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_SEL = 8'd1;

    localparam logic [1:0] INT_13MS   = 2'd0;
    localparam logic [1:0] INT_101MS  = 2'd1;
    localparam logic [1:0] INT_402MS  = 2'd2;
    localparam logic [1:0] INT_MANUAL = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00fe7;
    localparam logic [SCALE_W-1:0] SCALE_UNITY = 19'h00400;

    // upper ratio limit of each segment but the last, in 2^9 fixed point
    localparam logic [COEF_W-1:0] SEG_LIMIT [NSEG-1] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
    };
    localparam logic [COEF_W-1:0] SEG_OFFSET [NSEG] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [COEF_W-1:0] SEG_SLOPE [NSEG] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // payload carried through the divider stages
    typedef struct packed {
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             zero;   // broadband count scaled to zero
        logic             big;    // quotient at or above 2^12
    } t_div;

endpackage

// ----- hdl/lux_piecewise_linear_calc.sv -----
// ============================================================================
// lux_piecewise_linear_calc : two-channel piecewise-linear lux estimate
//
//   channel   direction  beat payload
//   s_axis    in         tdata[15:0] broadband, tdata[31:16] infrared
//   m_axis    out        tdata[15:0] lux, tuser[0] saturated
//   cfg       in         index 0 gain_is_16x, index 1 integration_select
//
// One beat per cycle in, one beat per cycle out while m_axis is ready; two
// scaling stages, twelve divider stages (one ratio bit each), three lux stages.
// Every stage has its own valid bit and moves when empty or when the next
// stage moves, so bubbles close up behind a stalled output.
// Synchronous reset clears all valid bits and loads the register defaults.
// ============================================================================
module lux_piecewise_linear_calc
    import lpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [31:0]          i_s_axis_tdata,   // [15:0] broadband_count, [31:16] infrared_count
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [15:0] lux
    output logic [0:0]           o_m_axis_tuser,   // [0] saturated
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic       r_gain;
    logic [1:0] r_int_sel;
    logic       w_sc_vld;
    logic       w_sc_rdy;
    t_div       w_sc_div;
    logic       w_dv_vld;
    logic       w_dv_rdy;
    t_div       w_dv_div;
    logic       w_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= 1'b0;
            r_int_sel <= INT_402MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN:    r_gain    <= i_cfg_data[0];
                CFG_INT_SEL: r_int_sel <= i_cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    lpc_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_s_axis_tvalid),
        .o_rdy     (o_s_axis_tready),
        .i_bb      (i_s_axis_tdata[15:0]),
        .i_ir      (i_s_axis_tdata[31:16]),
        .i_gain    (r_gain),
        .i_int_sel (r_int_sel),
        .o_vld     (w_sc_vld),
        .i_rdy     (w_sc_rdy),
        .o_div     (w_sc_div)
    );

    lpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sc_vld),
        .o_rdy   (w_sc_rdy),
        .i_div   (w_sc_div),
        .o_vld   (w_dv_vld),
        .i_rdy   (w_dv_rdy),
        .o_div   (w_dv_div)
    );

    lpc_lux u_lux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_dv_vld),
        .o_rdy   (w_dv_rdy),
        .i_div   (w_dv_div),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_lux   (o_m_axis_tdata),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tuser = w_sat;

    // clipped result is always full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 16'hffff)
        else $error("saturated beat without full-scale lux");

    // input backpressure only when the whole pipe is full behind a stalled output
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled while pipeline could advance");

    a_cfg_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == CFG_INT_SEL |=> r_int_sel == $past(i_cfg_data[1:0]))
        else $error("integration select write lost");

    a_cfg_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index != CFG_GAIN |=> $stable(r_gain))
        else $error("gain changed by a write to another index");

endmodule

// ----- hdl/lpc_scale.sv -----
// ============================================================================
// lpc_scale : channel scaling and divider setup
// Stage A multiplies both raw counts by the gain/time factor; stage B flags
// the ratio corner cases and loads the first partial remainder.
// ============================================================================
module lpc_scale
    import lpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  logic [RAW_W-1:0] i_bb,
    input  logic [RAW_W-1:0] i_ir,
    input  logic             i_gain,
    input  logic [1:0]       i_int_sel,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_div             o_div
);

    logic [SCALE_W-1:0]        w_scale;
    logic [SCALE_W-1:0]        w_base;
    logic [RAW_W+SCALE_W-1:0]  w_p0;
    logic [RAW_W+SCALE_W-1:0]  w_p1;
    logic                      r_vld_a;
    logic [CNT_W-1:0]          r_c0_a;
    logic [CNT_W-1:0]          r_c1_a;
    logic                      r_vld_b;
    t_div                      r_div_b;
    t_div                      n_div_b;
    logic                      w_en_a;
    logic                      w_en_b;

    assign w_en_b = !r_vld_b || i_rdy;
    assign w_en_a = !r_vld_a || w_en_b;
    assign o_rdy  = w_en_a;

    always_comb begin
        case (i_int_sel)
            INT_13MS:  w_base = SCALE_13MS;
            INT_101MS: w_base = SCALE_101MS;
            default:   w_base = SCALE_UNITY;
        endcase
        w_scale = i_gain ? w_base : (w_base << 4);
    end

    assign w_p0 = {{SCALE_W{1'b0}}, i_bb} * {{RAW_W{1'b0}}, w_scale};
    assign w_p1 = {{SCALE_W{1'b0}}, i_ir} * {{RAW_W{1'b0}}, w_scale};

    always_comb begin
        n_div_b.c0   = r_c0_a;
        n_div_b.c1   = r_c1_a;
        n_div_b.rem  = {2'b00, r_c1_a[CNT_W-1:2]};
        n_div_b.q    = '0;
        n_div_b.zero = (r_c0_a == '0);
        // c1 >= 4*c0 puts the quotient at 2^12 or more: past the last segment limit
        n_div_b.big  = ({2'b00, r_c1_a} >= {r_c0_a, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_vld_a <= i_vld;
            end
            if (w_en_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_vld) begin
            r_c0_a <= w_p0[RAW_W+SCALE_W-1:SCALE_FRAC];
            r_c1_a <= w_p1[RAW_W+SCALE_W-1:SCALE_FRAC];
        end
        if (w_en_b && r_vld_a) begin
            r_div_b <= n_div_b;
        end
    end

    assign o_vld = r_vld_b;
    assign o_div = r_div_b;

endmodule

// ----- hdl/lpc_div.sv -----
// ============================================================================
// lpc_div : pipelined restoring divider for the channel ratio
// One quotient bit per stage, twelve stages, (c1 << 10) / c0.
// ============================================================================
module lpc_div
    import lpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_div i_div,
    output logic o_vld,
    input  logic i_rdy,
    output t_div o_div
);

    logic [Q_W-1:0] r_vld;
    logic [Q_W-1:0] w_en;
    t_div           r_st [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            localparam int B = Q_W - 1 - k;
            t_div          w_prev;
            logic          w_in_vld;
            t_div          n_st;
            logic          w_nbit;
            logic [CNT_W:0] w_sh;
            logic [CNT_W:0] w_diff;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_prev   = i_div;
                assign w_in_vld = i_vld;
            end else begin : g_next
                assign w_prev   = r_st[k-1];
                assign w_in_vld = r_vld[k-1];
            end

            if (k == Q_W - 1) begin : g_last
                assign w_en[k] = !r_vld[k] || i_rdy;
            end else begin : g_mid
                assign w_en[k] = !r_vld[k] || w_en[k+1];
            end

            // dividend is c1 << 10: only its bits 11 and 10 are nonzero below 2^12
            if (B >= 10) begin : g_dbit
                assign w_nbit = w_prev.c1[B-10];
            end else begin : g_zbit
                assign w_nbit = 1'b0;
            end

            always_comb begin
                w_sh   = {w_prev.rem, w_nbit};
                w_diff = w_sh - {1'b0, w_prev.c0};
                w_ge   = (w_sh >= {1'b0, w_prev.c0});
                n_st   = w_prev;
                n_st.rem  = w_ge ? w_diff[CNT_W-1:0] : w_sh[CNT_W-1:0];
                n_st.q[B] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= w_in_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k] && w_in_vld) begin
                    r_st[k] <= n_st;
                end
            end
        end
    endgenerate

    assign o_rdy = w_en[0];
    assign o_vld = r_vld[Q_W-1];
    assign o_div = r_st[Q_W-1];

endmodule

// ----- hdl/lpc_lux.sv -----
// ============================================================================
// lpc_lux : segment lookup, weighted difference and output register
// Stage S picks slope/offset, stage M forms both products, stage O clamps,
// rounds, shifts and saturates.
// ============================================================================
module lpc_lux
    import lpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  t_div             i_div,
    output logic             o_vld,
    input  logic             i_rdy,
    output logic [LUX_W-1:0] o_lux,
    output logic             o_sat
);

    localparam int VAL_W = PROD_W + 1 - LUX_FRAC;

    logic [2:0]        n_seg;
    logic              r_vld_s;
    logic [CNT_W-1:0]  r_c0_s;
    logic [CNT_W-1:0]  r_c1_s;
    logic [COEF_W-1:0] r_off_s;
    logic [COEF_W-1:0] r_slp_s;
    logic              r_vld_m;
    logic [PROD_W-1:0] r_pos_m;
    logic [PROD_W-1:0] r_neg_m;
    logic              r_vld_o;
    logic [LUX_W-1:0]  r_lux_o;
    logic              r_sat_o;
    logic [PROD_W-1:0] w_diff;
    logic [PROD_W:0]   w_rnd;
    logic [VAL_W-1:0]  w_val;
    logic              w_en_s;
    logic              w_en_m;
    logic              w_en_o;

    assign w_en_o = !r_vld_o || i_rdy;
    assign w_en_m = !r_vld_m || w_en_o;
    assign w_en_s = !r_vld_s || w_en_m;
    assign o_rdy  = w_en_s;

    // rounded ratio (q + 1) >> 1 exceeds L exactly when q > 2L
    always_comb begin
        n_seg = 3'd7;
        for (int i = NSEG - 2; i >= 0; i--) begin
            if (i_div.q <= {1'b0, SEG_LIMIT[i], 1'b0}) begin
                n_seg = 3'(i);
            end
        end
        if (i_div.zero) begin
            n_seg = 3'd0;
        end else if (i_div.big) begin
            n_seg = 3'd7;
        end
    end

    assign w_diff = (r_pos_m > r_neg_m) ? (r_pos_m - r_neg_m) : '0;
    assign w_rnd  = {1'b0, w_diff} + (PROD_W+1)'(1 << (LUX_FRAC - 1));
    assign w_val  = w_rnd[PROD_W:LUX_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s <= 1'b0;
            r_vld_m <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            if (w_en_s) begin
                r_vld_s <= i_vld;
            end
            if (w_en_m) begin
                r_vld_m <= r_vld_s;
            end
            if (w_en_o) begin
                r_vld_o <= r_vld_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s && i_vld) begin
            r_c0_s  <= i_div.c0;
            r_c1_s  <= i_div.c1;
            r_off_s <= SEG_OFFSET[n_seg];
            r_slp_s <= SEG_SLOPE[n_seg];
        end
        if (w_en_m && r_vld_s) begin
            r_pos_m <= {{COEF_W{1'b0}}, r_c0_s} * {{CNT_W{1'b0}}, r_off_s};
            r_neg_m <= {{COEF_W{1'b0}}, r_c1_s} * {{CNT_W{1'b0}}, r_slp_s};
        end
        if (w_en_o && r_vld_m) begin
            r_sat_o <= (w_val[VAL_W-1:LUX_W] != '0);
            r_lux_o <= (w_val[VAL_W-1:LUX_W] != '0) ? '1 : w_val[LUX_W-1:0];
        end
    end

    assign o_vld = r_vld_o;
    assign o_lux = r_lux_o;
    assign o_sat = r_sat_o;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for lux_piecewise_linear_calc
// Streams channel-count pairs through the pipeline and compares every output
// beat with a local fixed-point lux estimate. It covers all gain and
// integration settings, segment knees, saturation, zero broadband counts and
// ignored register indexes, under random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb
    import lpc_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hff;
    localparam logic [63:0] SCALE_T13_Q10  = 64'h7517;
    localparam logic [63:0] SCALE_T101_Q10 = 64'h0fe7;
    localparam int          PIPE_DEPTH     = 17;
    localparam int          RANDOM_BLOCK   = 54;   // samples per setting in each idle phase

    typedef struct packed {
        logic [15:0] lux;
        logic        saturated;
    } t_lux_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [31:0]          i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [15:0]          o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    t_lux_beat   lux_expected_q[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 83;

    // shadow copy of the block's registers
    logic        cfg_gain_16x = 1'b0;
    logic [1:0]  cfg_int_sel = INT_402MS;

    lux_piecewise_linear_calc i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // upper ratio bound of segment k, 2^9 fixed point
    function automatic logic [9:0] ratio_knee(input int k);
        case (k)
            0:       return 10'h040;
            1:       return 10'h080;
            2:       return 10'h0c0;
            3:       return 10'h100;
            4:       return 10'h138;
            5:       return 10'h19a;
            6:       return 10'h29a;
            default: return 10'h3ff;
        endcase
    endfunction

    function automatic t_lux_beat lux_estimate(input logic [15:0] bb, input logic [15:0] ir,
                                               input logic gain16, input logic [1:0] isel);
        logic [63:0] scale, c0, c1, ratio, pos, neg, diff;
        logic [9:0]  offset, slope;
        int          seg;
        t_lux_beat   r;
        case (isel)
            INT_13MS:  scale = SCALE_T13_Q10;
            INT_101MS: scale = SCALE_T101_Q10;
            default:   scale = 64'd1 << 10;
        endcase
        if (!gain16) scale = scale << 4;
        c0 = ({48'd0, bb} * scale) >> 10;
        c1 = ({48'd0, ir} * scale) >> 10;
        ratio = (c0 != 0) ? (c1 << 10) / c0 : 64'd0;
        ratio = (ratio + 64'd1) >> 1;
        seg = 0;
        while (seg < 7 && ratio > {54'd0, ratio_knee(seg)}) seg++;
        case (seg)
            0:       begin offset = 10'h1f2; slope = 10'h1be; end
            1:       begin offset = 10'h214; slope = 10'h2d1; end
            2:       begin offset = 10'h23f; slope = 10'h37b; end
            3:       begin offset = 10'h270; slope = 10'h3fe; end
            4:       begin offset = 10'h16f; slope = 10'h1fc; end
            5:       begin offset = 10'h0d2; slope = 10'h0fb; end
            6:       begin offset = 10'h018; slope = 10'h012; end
            default: begin offset = 10'h000; slope = 10'h000; end
        endcase
        pos = c0 * {54'd0, offset};
        neg = c1 * {54'd0, slope};
        diff = (pos > neg) ? pos - neg : 64'd0;
        diff = (diff + (64'd1 << 13)) >> 14;
        if (diff > 64'hffff) begin
            r.lux = 16'hffff;
            r.saturated = 1'b1;
        end else begin
            r.lux = diff[15:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // receiver side: random backpressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output beat checker
    always @(posedge i_clk) begin
        t_lux_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (lux_expected_q.size() == 0) begin
                flag_mismatch("unexpected beat, lux", 0, o_m_axis_tdata);
            end else begin
                want = lux_expected_q.pop_front();
                if (o_m_axis_tdata !== want.lux)
                    flag_mismatch("lux", want.lux, o_m_axis_tdata);
                if (o_m_axis_tuser[0] !== want.saturated)
                    flag_mismatch("saturated", want.saturated, o_m_axis_tuser[0]);
            end
        end
    end

    task automatic send_sample(input logic [15:0] bb, input logic [15:0] ir);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ir, bb};
        do @(posedge i_clk); while (!o_s_axis_tready);
        lux_expected_q.push_back(lux_estimate(bb, ir, cfg_gain_16x, cfg_int_sel));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (lux_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_GAIN)
            cfg_gain_16x = data[0];
        else if (idx == CFG_INT_SEL)
            cfg_int_sel = data[1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample();
        logic [15:0] bb, ir;
        int unsigned target;
        case ($urandom_range(9))
            0, 1, 2: begin
                bb = 16'($urandom);
                ir = 16'($urandom);
            end
            3, 4, 5: begin
                // land close to a segment knee
                bb = 16'($urandom_range(65535, 1));
                target = (int'(bb) * int'(ratio_knee($urandom_range(6)))) >> 9;
                target = target + $urandom_range(4);
                target = (target >= 2) ? target - 2 : 0;
                ir = (target > 65535) ? 16'hffff : target[15:0];
            end
            6: begin
                bb = 16'($urandom_range(63));
                ir = 16'($urandom_range(63));
            end
            7: begin
                bb = 16'd0;
                ir = $urandom_range(1) ? 16'($urandom) : 16'd0;
            end
            8: begin
                bb = 16'($urandom_range(65535, 60000));
                ir = bb >> $urandom_range(8, 1);
            end
            default: begin
                bb = 16'($urandom);
                ir = 16'd0;
            end
        endcase
        return {ir, bb};
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'd0, 16'd0);
        send_sample(16'hffff, 16'hffff);
        send_sample(16'hffff, 16'd0);
        send_sample(16'd0, 16'hffff);     // zero broadband, clamp to zero
        send_sample(16'd1, 16'd1);
    endtask

    task automatic test_segment_knees();
        int k;
        // unity scale and 512 broadband: ratio equals the infrared count
        write_register(CFG_GAIN, 8'd1);
        write_register(CFG_INT_SEL, {6'd0, INT_MANUAL});
        for (k = 0; k < 7; k++) begin
            send_sample(16'd512, {6'd0, ratio_knee(k)});
            send_sample(16'd512, {6'd0, ratio_knee(k)} + 16'd1);
        end
    endtask

    task automatic test_saturation();
        write_register(CFG_GAIN, 8'd0);
        write_register(CFG_INT_SEL, {6'd0, INT_13MS});
        send_sample(16'hffff, 16'd0);
        send_sample(16'hffff, 16'd1000);
    endtask

    task automatic test_register_writes();
        // upper data bits are dropped, unknown indexes ignored
        write_register(CFG_GAIN, 8'hff);
        write_register(CFG_INT_SEL, 8'hfd);
        write_register(CFG_UNUSED_LO, 8'hfe);
        write_register(CFG_UNUSED_HI, 8'h00);
        send_sample(16'd40000, 16'd9000);
        send_sample(16'd1234, 16'd321);
    endtask

    task automatic test_random_traffic();
        int phase, setting, n;
        logic [CFG_DAT_W-1:0] d;
        logic [31:0] s;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 31; recv_idle_pct = 83; end
                1:       begin send_idle_pct = 83; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (setting = 0; setting < 8; setting++) begin
                d = 8'($urandom);
                d[0] = setting[0];
                write_register(CFG_GAIN, d);
                d = 8'($urandom);
                d[1:0] = setting[2:1];
                write_register(CFG_INT_SEL, d);
                write_register(8'($urandom_range(255, 2)), 8'($urandom));
                for (n = 0; n < RANDOM_BLOCK; n++) begin
                    s = pick_sample();
                    send_sample(s[15:0], s[31:16]);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_segment_knees();
        test_saturation();
        test_register_writes();
        test_random_traffic();

        wait_results_drained();
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
